// ----- rtl/permuted_circulant_determinant_macros.svh -----
// ----------------------------------------------------------------------------
// permuted circulant determinant assertion macros
// concurrent check wrappers shared by the rtl files, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef PERMUTED_CIRCULANT_DETERMINANT_MACROS_SVH
`define PERMUTED_CIRCULANT_DETERMINANT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while rst is high
`define PCD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define PCD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define PCD_ASSERT_IMP(name, ante, cons)
`define PCD_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ----- rtl/pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcd_pkg
// constants, state encoding and modular helpers for the permuted circulant
// determinant block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcd_pkg;

  localparam int MAX_ORDER  = 64;
  localparam int IDX_W      = $clog2(MAX_ORDER);
  localparam int CNT_W      = IDX_W + 1;
  localparam int POLY_DEPTH = MAX_ORDER + 1;
  localparam int PIDX_W     = $clog2(POLY_DEPTH);
  localparam int VAL_W      = 30;

  // prime modulus and derived constants
  localparam logic [VAL_W-1:0] P         = 30'd1000000007;
  localparam logic [VAL_W-1:0] P_MINUS_1 = 30'd1000000006;
  localparam logic [VAL_W-1:0] P_MINUS_2 = 30'd1000000005;
  localparam logic [31:0]      P_TWICE   = 32'd2000000014;
  // floor(2^60 / P) for barrett reduction
  localparam logic [30:0]      MU        = 31'd1152921496;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_TRIMB_RD,
    ST_TRIMB_CHK,
    ST_E_TOP,
    ST_LAST_RD,
    ST_INV_RD,
    ST_INV_DONE,
    ST_DIV_TOP,
    ST_DIV_LEAD,
    ST_DIV_F_WAIT,
    ST_DIV_J_TOP,
    ST_DIV_J_RD,
    ST_DIV_J_WAIT,
    ST_TRIMA_RD,
    ST_TRIMA_CHK,
    ST_POST_RD,
    ST_POW_CHK,
    ST_POW_WA,
    ST_POW_SQ,
    ST_POW_WB,
    ST_RP_GO,
    ST_RP_WAIT,
    ST_DONE
  } state_t;

  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    logic [VAL_W:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, P};
    return (s >= {1'b0, P}) ? d[VAL_W-1:0] : s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] mod_neg(input logic [VAL_W-1:0] a);
    return (a == '0) ? '0 : P - a;
  endfunction

endpackage

// ----- rtl/pcd_modmul.sv -----
// ----------------------------------------------------------------------------
// pcd_modmul
// four-stage pipelined multiplier modulo P with barrett reduction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "permuted_circulant_determinant_macros.svh"

module pcd_modmul
  import pcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic             done,
  output logic [VAL_W-1:0] result
);

  logic [3:0]  vld;
  logic [59:0] prod;
  logic [61:0] q2;
  logic [31:0] low2;
  logic [31:0] low3;
  logic [31:0] qp3;
  logic [60:0] qp_full;
  logic [31:0] rem;

  assign qp_full = q2[61:31] * P;
  assign rem     = low3 - qp3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    q2   <= prod[59:29] * MU;
    low2 <= prod[31:0];
    qp3  <= qp_full[31:0];
    low3 <= low2;
    // remainder is below 3P, at most two corrections
    if (rem >= P_TWICE) begin
      result <= VAL_W'(rem - P_TWICE);
    end else if (rem >= {2'b00, P}) begin
      result <= VAL_W'(rem - {2'b00, P});
    end else begin
      result <= rem[VAL_W-1:0];
    end
  end

  assign done = vld[3];

  `PCD_ASSERT_IMP(a_mul_latency, start, ##4 done)
  `PCD_ASSERT_IMP(a_mul_no_spurious, done, $past(start, 4))
  `PCD_ASSERT_IMP(a_mul_range, done, result < P)

endmodule

// ----- rtl/permuted_circulant_determinant.sv -----
// ----------------------------------------------------------------------------
// permuted_circulant_determinant
// determinant mod 1000000007 of the matrix built from a row vector and a
// single-cycle permutation, via the resultant of x^n-1 and the permuted row
// ----------------------------------------------------------------------------
// Load n requests (n from the size register, 0 reads as 1, above 64 as 64),
// each carrying one row coefficient and the permutation image of its position.
// Requests are taken only while idle. The n-th request starts the computation
// and the block takes no request until the determinant has been handed to the
// output register. The computation walks the permutation, then runs euclidean
// polynomial remainders over two 65-entry coefficient memories with a shared
// 4-stage modular multiplier for coefficient updates and leading-coefficient
// inverses. Anything that is not one n-cycle, an index at or above n, or an
// all-zero row yields 0. Writing size restarts loading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "permuted_circulant_determinant_macros.svh"

module permuted_circulant_determinant
  import pcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,      // size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,       // [29:0] coefficient, [35:30] next_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata        // [29:0] determinant
);

  // configuration and load control
  logic [6:0]       size;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] load_count;
  logic [CNT_W-1:0] slot;
  logic             accept;
  logic [VAL_W-1:0] coef_in;
  logic [VAL_W-1:0] coef_red;

  state_t state, state_next, ret_state;

  // load memory holds {next_index, coefficient} per position
  logic [IDX_W+VAL_W-1:0] load_mem [0:MAX_ORDER-1];
  logic [IDX_W+VAL_W-1:0] ld_q;

  // two coefficient memories, role of dividend / divisor swaps with sel
  logic [VAL_W-1:0]  poly0 [0:POLY_DEPTH-1];
  logic [VAL_W-1:0]  poly1 [0:POLY_DEPTH-1];
  logic [VAL_W-1:0]  poly0_q, poly1_q;
  logic [VAL_W-1:0]  pa_q, pb_q;
  logic              sel;
  logic [PIDX_W-1:0] rd_a_idx, rd_b_idx, p0_raddr, p1_raddr;
  logic              wr_a_en, wr_b_en, p0_we, p1_we;
  logic [PIDX_W-1:0] wr_idx;
  logic [VAL_W-1:0]  wr_data;

  // permutation walk
  logic [CNT_W-1:0]     i;
  logic [IDX_W-1:0]     x;
  logic [MAX_ORDER-1:0] visited;
  logic [MAX_ORDER-1:0] visited_now;
  logic [MAX_ORDER-1:0] above_bits;
  logic                 above_par;
  logic                 inv_par;
  logic                 neg;
  logic [IDX_W-1:0]     walk_nx;
  logic                 walk_last;
  logic                 walk_fail;

  // euclid state
  logic signed [7:0] da, db, d0, k_deg;
  logic [CNT_W-1:0]  j;
  logic              last_round;
  logic [VAL_W-1:0]  inv, f, tmp, rp;
  logic [VAL_W-1:0]  pw_base, pw_exp, pw_acc;
  logic [VAL_W-1:0]  fin;

  // shared multiplier
  logic             mul_start, mul_done;
  logic [VAL_W-1:0] mul_a, mul_b, mul_res;

  pcd_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  assign n = (size == '0) ? CNT_W'(1) :
             (size > 7'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : CNT_W'(size);
  assign accept   = s_tvalid && s_tready;
  assign slot     = (load_count >= n) ? '0 : load_count;
  // inputs below 2^30 are under 2P, one subtract reduces them
  assign coef_in  = s_tdata[29:0];
  assign coef_red = (coef_in >= P) ? coef_in - P : coef_in;

  assign p0_raddr = sel ? rd_b_idx : rd_a_idx;
  assign p1_raddr = sel ? rd_a_idx : rd_b_idx;
  assign p0_we    = sel ? wr_b_en : wr_a_en;
  assign p1_we    = sel ? wr_a_en : wr_b_en;
  assign pa_q     = sel ? poly1_q : poly0_q;
  assign pb_q     = sel ? poly0_q : poly1_q;

  assign k_deg = da - db + $signed({1'b0, j});
  assign fin   = neg ? mod_neg(rp) : rp;

  // walk checks and inversion parity of the visiting order
  assign walk_nx     = ld_q[IDX_W+VAL_W-1:VAL_W];
  assign walk_last   = (i == n - CNT_W'(1));
  assign visited_now = visited | (MAX_ORDER'(1) << x);
  always_comb begin
    for (int b = 0; b < MAX_ORDER; b++) begin
      above_bits[b] = visited[b] && (b > int'(x));
    end
  end
  assign above_par = ^above_bits;
  assign walk_fail = ({1'b0, walk_nx} >= n) ||
                     (walk_last ? (walk_nx != '0) : visited_now[walk_nx]);

  // memories
  always_ff @(posedge clk) begin
    if (accept) begin
      load_mem[slot[IDX_W-1:0]] <= {s_tdata[35:30], coef_red};
    end
    ld_q <= load_mem[x];
  end

  always_ff @(posedge clk) begin
    if (p0_we) begin
      poly0[wr_idx] <= wr_data;
    end
    poly0_q <= poly0[p0_raddr];
  end

  always_ff @(posedge clk) begin
    if (p1_we) begin
      poly1[wr_idx] <= wr_data;
    end
    poly1_q <= poly1[p1_raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (accept && (slot + CNT_W'(1) >= n)) state_next = ST_INIT;
      ST_INIT:       if (i == n) state_next = ST_WALK_RD;
      ST_WALK_RD:    state_next = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (walk_fail) state_next = ST_DONE;
        else if (walk_last) state_next = ST_TRIMB_RD;
        else state_next = ST_WALK_RD;
      end
      ST_TRIMB_RD:   state_next = (db < 8'sd0) ? ST_E_TOP : ST_TRIMB_CHK;
      ST_TRIMB_CHK:  state_next = (pb_q == '0) ? ST_TRIMB_RD : ST_E_TOP;
      ST_E_TOP: begin
        if (db < 8'sd0) state_next = ST_DONE;
        else if (db == 8'sd0) state_next = ST_LAST_RD;
        else state_next = ST_INV_RD;
      end
      ST_LAST_RD:    state_next = ST_POW_CHK;
      ST_INV_RD:     state_next = ST_POW_CHK;
      ST_INV_DONE:   state_next = ST_DIV_TOP;
      ST_DIV_TOP:    state_next = (da >= db) ? ST_DIV_LEAD : ST_POST_RD;
      ST_DIV_LEAD:   state_next = ST_DIV_F_WAIT;
      ST_DIV_F_WAIT: if (mul_done) state_next = ST_DIV_J_TOP;
      ST_DIV_J_TOP:  state_next = ($signed({1'b0, j}) < db) ? ST_DIV_J_RD : ST_TRIMA_RD;
      ST_DIV_J_RD:   state_next = ST_DIV_J_WAIT;
      ST_DIV_J_WAIT: if (mul_done) state_next = ST_DIV_J_TOP;
      ST_TRIMA_RD:   state_next = (da < 8'sd0) ? ST_DIV_TOP : ST_TRIMA_CHK;
      ST_TRIMA_CHK:  state_next = (pa_q == '0) ? ST_TRIMA_RD : ST_DIV_TOP;
      ST_POST_RD:    state_next = ST_POW_CHK;
      ST_POW_CHK:    state_next = (pw_exp == '0) ? ret_state : ST_POW_WA;
      ST_POW_WA:     if (mul_done) state_next = ST_POW_SQ;
      ST_POW_SQ:     state_next = ST_POW_WB;
      ST_POW_WB:     if (mul_done) state_next = ST_POW_CHK;
      ST_RP_GO:      state_next = ST_RP_WAIT;
      ST_RP_WAIT:    if (mul_done) state_next = last_round ? ST_DONE : ST_E_TOP;
      ST_DONE:       if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // memory ports and multiplier requests
  always_comb begin
    s_tready  = (state == ST_IDLE);
    rd_a_idx  = '0;
    rd_b_idx  = '0;
    wr_a_en   = 1'b0;
    wr_b_en   = 1'b0;
    wr_idx    = '0;
    wr_data   = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_INIT: begin
        // dividend starts as x^n - 1
        wr_a_en = 1'b1;
        wr_idx  = i;
        if (i == '0) wr_data = P_MINUS_1;
        else if (i == n) wr_data = VAL_W'(1);
        else wr_data = '0;
      end
      ST_WALK_CHK: begin
        // divisor coefficients land in reverse walk order
        wr_b_en = 1'b1;
        wr_idx  = n - CNT_W'(1) - i;
        wr_data = ld_q[VAL_W-1:0];
      end
      ST_TRIMB_RD:   rd_b_idx = db[PIDX_W-1:0];
      ST_E_TOP:      rd_b_idx = db[PIDX_W-1:0];
      ST_DIV_TOP: begin
        rd_a_idx = da[PIDX_W-1:0];
        rd_b_idx = db[PIDX_W-1:0];
      end
      ST_DIV_LEAD: begin
        mul_start = 1'b1;
        mul_a     = inv;
        mul_b     = mod_neg(pa_q);
      end
      ST_DIV_J_TOP: begin
        rd_a_idx = k_deg[PIDX_W-1:0];
        rd_b_idx = j;
      end
      ST_DIV_J_RD: begin
        mul_start = 1'b1;
        mul_a     = f;
        mul_b     = pb_q;
      end
      ST_DIV_J_WAIT: begin
        wr_a_en = mul_done;
        wr_idx  = k_deg[PIDX_W-1:0];
        wr_data = mod_add(tmp, mul_res);
      end
      ST_TRIMA_RD:   rd_a_idx = da[PIDX_W-1:0];
      ST_POW_CHK: begin
        mul_start = (pw_exp != '0);
        mul_a     = pw_acc;
        mul_b     = pw_base;
      end
      ST_POW_SQ: begin
        mul_start = 1'b1;
        mul_a     = pw_base;
        mul_b     = pw_base;
      end
      ST_RP_GO: begin
        mul_start = 1'b1;
        mul_a     = rp;
        mul_b     = pw_acc;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      size       <= 7'd1;
      load_count <= '0;
      visited    <= '0;
      m_tvalid   <= 1'b0;
      rp         <= VAL_W'(1);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        size       <= cfg_data;
        load_count <= '0;
      end else if (accept) begin
        load_count <= (slot + CNT_W'(1) >= n) ? '0 : slot + CNT_W'(1);
      end
      if (state == ST_INIT && i == n) begin
        visited <= '0;
      end else if (state == ST_WALK_CHK) begin
        visited <= visited_now;
      end
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_INIT:     if (i == n) rp <= VAL_W'(1);
        ST_WALK_CHK: if (walk_fail) rp <= '0;
        ST_E_TOP:    if (db < 8'sd0) rp <= '0;
        ST_RP_WAIT: begin
          if (mul_done) begin
            if (!last_round && d0[0] && db[0]) rp <= mod_neg(mul_res);
            else rp <= mul_res;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, fin};
    end
    unique case (state)
      ST_IDLE: begin
        i   <= '0;
        sel <= 1'b0;
      end
      ST_INIT: begin
        if (i == n) begin
          i       <= '0;
          x       <= '0;
          inv_par <= 1'b0;
          da      <= $signed({1'b0, n});
        end else begin
          i <= i + CNT_W'(1);
        end
      end
      ST_WALK_CHK: begin
        inv_par <= inv_par ^ above_par;
        x       <= walk_nx;
        i       <= i + CNT_W'(1);
        db      <= $signed({1'b0, n}) - 8'sd1;
        // sign of the reversed visiting order: its inversions plus n(n-1)/2
        neg     <= walk_fail ? 1'b0 : (inv_par ^ above_par ^ n[1]);
      end
      ST_TRIMB_CHK: if (pb_q == '0) db <= db - 8'sd1;
      ST_LAST_RD: begin
        pw_base    <= pb_q;
        pw_exp     <= VAL_W'(da[6:0]);
        pw_acc     <= VAL_W'(1);
        last_round <= 1'b1;
        ret_state  <= ST_RP_GO;
      end
      ST_INV_RD: begin
        pw_base    <= pb_q;
        pw_exp     <= P_MINUS_2;
        pw_acc     <= VAL_W'(1);
        d0         <= da;
        last_round <= 1'b0;
        ret_state  <= ST_INV_DONE;
      end
      ST_INV_DONE:   inv <= pw_acc;
      ST_DIV_F_WAIT: begin
        if (mul_done) begin
          f <= mul_res;
          j <= '0;
        end
      end
      ST_DIV_J_TOP:  if (!($signed({1'b0, j}) < db)) da <= da - 8'sd1;
      ST_DIV_J_RD:   tmp <= pa_q;
      ST_DIV_J_WAIT: if (mul_done) j <= j + CNT_W'(1);
      ST_TRIMA_CHK:  if (pa_q == '0) da <= da - 8'sd1;
      ST_POST_RD: begin
        pw_base   <= pb_q;
        pw_exp    <= VAL_W'(d0 - da);
        pw_acc    <= VAL_W'(1);
        ret_state <= ST_RP_GO;
      end
      ST_POW_WA:     if (mul_done && pw_exp[0]) pw_acc <= mul_res;
      ST_POW_WB: begin
        if (mul_done) begin
          pw_base <= mul_res;
          pw_exp  <= pw_exp >> 1;
        end
      end
      ST_RP_WAIT: begin
        // end of a round: remainder becomes the new divisor
        if (mul_done && !last_round) begin
          sel <= ~sel;
          da  <= db;
          db  <= da;
        end
      end
      default: begin
      end
    endcase
  end

  `PCD_ASSERT_IMP(a_out_range, m_tvalid, (m_tdata[29:0] < P) && (m_tdata[31:30] == 2'b00))
  `PCD_ASSERT_IMP(a_walk_marks, state == ST_WALK_CHK, $countones(visited) == int'(i))
  `PCD_ASSERT_IMP(a_start_on_load, (state == ST_IDLE) && (state_next == ST_INIT), accept)
  `PCD_ASSERT_IMP(a_div_degrees, state == ST_DIV_J_TOP, (da >= db) && (db > 8'sd0))

endmodule

// ----- tb/sv/pcd_checker.sv -----
// ----------------------------------------------------------------------------
// pcd_checker
// watches the size register and both streams, predicts each determinant and
// compares it with what the block hands out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcd_checker
  import pcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          results
);

  localparam longint unsigned MODV = 64'd1000000007;

  logic [6:0]       order_reg;
  int               fill;
  logic [VAL_W-1:0] row_mem [MAX_ORDER];
  logic [5:0]       image_mem [MAX_ORDER];
  logic [VAL_W-1:0] det_q [$];

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
    return (a * b) % MODV;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e);
    longint unsigned r;
    r = 1;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b);
      b = mul_mod(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  // determinant of the permuted circulant of the loaded row, order n
  function automatic logic [VAL_W-1:0] determinant(int n);
    bit              seen [MAX_ORDER];
    int              walk [MAX_ORDER];
    longint unsigned pa [MAX_ORDER+1];
    longint unsigned pb [MAX_ORDER+1];
    longint unsigned tmp [MAX_ORDER+1];
    longint unsigned prod, inv, f;
    int              x, nx, j, da, db, d0, t;
    bit              neg;
    x = 0;
    foreach (seen[k]) seen[k] = 0;
    for (int i = 0; i < n; i++) begin
      seen[x] = 1;
      walk[n-1-i] = x;
      nx = image_mem[x];
      if (nx >= n) return '0;
      if (i == n - 1) begin
        if (nx != 0) return '0;
      end else if (seen[nx]) begin
        return '0;
      end
      x = nx;
    end
    // sign from cycle parity of the walk order
    foreach (seen[k]) seen[k] = 0;
    neg = n[0];
    for (int i = 0; i < n; i++) begin
      if (!seen[i]) begin
        j = i;
        while (!seen[j]) begin
          seen[j] = 1;
          j = walk[j];
        end
        neg = !neg;
      end
    end
    for (int i = 0; i <= n; i++) pa[i] = 0;
    pa[0] = MODV - 1;
    pa[n] = 1;
    da = n;
    for (int i = 0; i < n; i++) pb[i] = row_mem[walk[i]];
    db = n - 1;
    while (db >= 0 && pb[db] == 0) db--;
    prod = 1;
    forever begin
      if (db < 0) begin
        prod = 0;
        break;
      end
      if (db == 0) begin
        prod = mul_mod(prod, pow_mod(pb[0], da));
        break;
      end
      inv = pow_mod(pb[db], MODV - 2);
      d0 = da;
      while (da >= db) begin
        f = mul_mod(inv, (MODV - pa[da]) % MODV);
        for (int k = 0; k < db; k++)
          pa[da-db+k] = (pa[da-db+k] + mul_mod(f, pb[k])) % MODV;
        da--;
        while (da >= 0 && pa[da] == 0) da--;
      end
      prod = mul_mod(prod, pow_mod(pb[db], d0 - da));
      if (d0[0] && db[0]) prod = (MODV - prod) % MODV;
      tmp = pa; pa = pb; pb = tmp;
      t = da; da = db; db = t;
    end
    if (neg) prod = (MODV - prod) % MODV;
    return prod[VAL_W-1:0];
  endfunction

  assign pending = det_q.size();

  always @(posedge clk) begin
    int n;
    logic [VAL_W-1:0] want;
    if (rst) begin
      order_reg <= 7'd1;
      fill = 0;
      errors = 0;
      results = 0;
      det_q.delete();
    end else begin
      if (cfg_we) begin
        order_reg <= cfg_data;
        fill = 0;
      end
      if (s_tvalid && s_tready) begin
        n = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
        if (fill >= n) fill = 0;
        row_mem[fill] = VAL_W'({2'b0, s_tdata[29:0]} % MODV);
        image_mem[fill] = s_tdata[35:30];
        fill++;
        if (fill >= n) begin
          fill = 0;
          det_q.push_back(determinant(n));
        end
      end
      if (m_tvalid && m_tready) begin
        results++;
        if (det_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected determinant %0d", $time, m_tdata[29:0]);
        end else begin
          want = det_q.pop_front();
          if (m_tdata[29:0] !== want) begin
            errors++;
            $display("%0t: determinant expected %0d actual %0d", $time, want,
                     m_tdata[29:0]);
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the permuted circulant determinant block
// ----------------------------------------------------------------------------
// directed loads cover order extremes, reduced coefficients, out of range and
// repeated indices and all-zero rows; random phases then load mostly valid
// single-cycle permutations with random rows, plus broken ones, while both
// sides idle at random. the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pcd_pkg::*;

  localparam int          MODI     = 1000000007;
  localparam int          WD_LIMIT = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;

  int  errors, pending, results;
  int  sent = 0;
  int  phases = 0;
  int  quiet_cycles = 0;
  bit  calm = 0;          // no idling on either side while set
  bit  press_req = 0;     // asks the receiver for one long hold-off
  bit  press_done = 0;
  int  order_n;
  int  chain [MAX_ORDER];
  int  image [MAX_ORDER];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  permuted_circulant_determinant i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  pcd_checker i_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending), .results(results)
  );

  // watchdog: cycles with no accepted request, result or size write
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("[permuted_circulant_determinant] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (press_req && !press_done) begin
        m_tready <= 0;
        repeat (3000) @(negedge clk);
        press_done = 1;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 22);
        @(negedge clk);
      end
    end
  end

  // one request, called at a falling edge, returns at a falling edge
  task automatic send_req(input logic [29:0] coef, input logic [5:0] idx);
    while (!calm && $urandom_range(0, 99) < 22) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {4'b0, idx, coef};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // size write once every expected determinant has come back
  task automatic set_order(input logic [6:0] v);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we   <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    order_n = (v == 0) ? 1 : (v > MAX_ORDER) ? MAX_ORDER : int'(v);
    phases++;
  endtask

  // random single n-cycle into image[]
  task automatic make_cycle();
    int k, t;
    for (int i = 0; i < order_n; i++) chain[i] = i;
    for (int i = order_n - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = chain[i]; chain[i] = chain[k]; chain[k] = t;
    end
    for (int i = 0; i < order_n; i++) image[chain[i]] = chain[(i + 1) % order_n];
  endtask

  function automatic logic [29:0] rand_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 30'd0;
    if (r < 10) return P_MINUS_1;
    if (r < 15) return 30'($urandom_range(MODI, 30'h3FFFFFFF));
    return 30'($urandom_range(0, MODI - 1));
  endfunction

  // one frame: kind picks valid, sparse or zero rows and broken permutations
  task automatic send_frame(input int kind);
    int r;
    make_cycle();
    if (kind >= 85) begin
      for (int i = 0; i < order_n; i++) image[i] = $urandom_range(0, 63);
    end else if (kind >= 75) begin
      image[$urandom_range(0, order_n - 1)] = $urandom_range(0, 63);
    end
    for (int i = 0; i < order_n; i++) begin
      r = $urandom_range(0, 99);
      if (kind >= 65 && kind < 75 && (kind < 70 || r < 70))
        send_req(30'd0, 6'(image[i]));
      else
        send_req(rand_coef(), 6'(image[i]));
    end
  endtask

  initial begin
    int r, frames;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset order is 1: largest coefficient, then an index out of range
    send_req(P_MINUS_1, 6'd0);
    send_req(30'd12345, 6'd5);
    // size zero reads as order 1, all-ones coefficient is reduced on entry
    set_order(7'd0);
    send_req(30'h3FFFFFFF, 6'd0);
    // order 3: valid cycle, repeated index, all-zero row
    set_order(7'd3);
    send_req(30'd7, 6'd2); send_req(30'd11, 6'd0); send_req(30'd13, 6'd1);
    send_req(30'd7, 6'd1); send_req(30'd11, 6'd1); send_req(30'd13, 6'd0);
    send_req(30'd0, 6'd1); send_req(30'd0, 6'd2); send_req(30'd0, 6'd0);
    // order 4 with the largest index value
    set_order(7'd4);
    send_req(30'd1, 6'd1); send_req(30'd2, 6'd63); send_req(30'd3, 6'd3);
    send_req(30'd4, 6'd0);
    // a partial load cut short by a size write
    set_order(7'd5);
    send_req(30'd9, 6'd1); send_req(30'd9, 6'd2);

    // largest order, and an oversized setting saturated to it
    set_order(7'd64);
    send_frame(0);
    set_order(7'd127);
    send_frame(0);

    calm = 1;
    while (sent < 1050) begin
      if (sent > 300) calm = 0;
      r = $urandom_range(0, 99);
      if (r < 70)      set_order(7'($urandom_range(1, 6)));
      else if (r < 95) set_order(7'($urandom_range(7, 16)));
      else             set_order(7'($urandom_range(17, 32)));
      if (sent > 500 && !press_req && order_n <= 4) press_req = 1;
      frames = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) send_frame($urandom_range(0, 99));
      // occasionally leave a frame half loaded before the next size write
      if ($urandom_range(0, 9) == 0 && order_n > 1)
        send_req(rand_coef(), 6'($urandom_range(0, 63)));
    end
    s_tvalid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("sent %0d requests over %0d size settings, %0d determinants checked",
             sent, phases, results);
    $display("orders from 1 to 64, long receiver hold-off %s",
             press_done ? "done" : "not reached");
    if (errors == 0) begin
      $display("[permuted_circulant_determinant] OK");
    end else begin
      $display("[permuted_circulant_determinant] ERROR");
    end
    $finish;
  end

endmodule
